// ----- rtl/smg_pkg.sv -----
// smg_pkg: shared types, codes and constants of the uv sphere mesh generator
// used by smg_phase_div, smg_sincos and uv_sphere_mesh_generator; no dependencies
package smg_pkg;

  // request opcodes
  typedef enum logic {
    OP_VERTEX = 1'b0,
    OP_CELL   = 1'b1
  } op_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_VERTEX   = 2'd0,
    KIND_TRIANGLE = 2'd1,
    KIND_RANGE    = 2'd2
  } kind_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_STACK_COUNT  = 3'd0,
    CFG_SECTOR_COUNT = 3'd1,
    CFG_CENTER_X     = 3'd2,
    CFG_CENTER_Y     = 3'd3,
    CFG_CENTER_Z     = 3'd4,
    CFG_RADIUS       = 3'd5
  } cfg_e;

  // input transaction
  typedef struct packed {
    op_e        opcode;
    logic [7:0] ring_index;
    logic [7:0] segment_index;
  } in_t;

  // output transaction
  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [16:0]        color_red;
    logic [16:0]        color_green;
    logic [16:0]        color_blue;
    logic [15:0]        corner_a;
    logic [15:0]        corner_b;
    logic [15:0]        corner_c;
    logic               last;
  } out_t;

  // phase divider: 40 numerator bits, 8 bits retired per stage
  localparam int unsigned DIV_STAGES = 5;
  localparam int unsigned DIV_STEPS  = 8;
  localparam int unsigned DIV_NUM_W  = DIV_STAGES * DIV_STEPS;

  // sine/cosine unit pipeline depth in register stages
  localparam int unsigned SC_LAT = 16;

  // pi in Q32
  localparam logic [33:0] PI_Q32 = 34'h3_243F_6A89;

  // taylor series step counts
  localparam int unsigned SIN_STEPS = 5;
  localparam int unsigned COS_STEPS = 6;

  // exact reciprocal multipliers for the series divisors (30 bit dividends)
  function automatic logic [31:0] sin_mul(int unsigned k);
    case (k)
      0:       return 32'd1249445032; // 110
      1:       return 32'd1908874354; // 72
      2:       return 32'd1636178018; // 42
      3:       return 32'd1717986919; // 20
      default: return 32'd1431655766; // 6
    endcase
  endfunction

  function automatic int unsigned sin_shift(int unsigned k);
    case (k)
      0:       return 37;
      1:       return 37;
      2:       return 36;
      3:       return 35;
      default: return 33;
    endcase
  endfunction

  function automatic logic [31:0] cos_mul(int unsigned k);
    case (k)
      0:       return 32'd2082408386; // 132
      1:       return 32'd1527099484; // 90
      2:       return 32'd1227133514; // 56
      3:       return 32'd1145324613; // 30
      4:       return 32'd1431655766; // 12
      default: return 32'd1073741824; // 2
    endcase
  endfunction

  function automatic int unsigned cos_shift(int unsigned k);
    case (k)
      0:       return 38;
      1:       return 37;
      2:       return 36;
      3:       return 35;
      4:       return 34;
      default: return 31;
    endcase
  endfunction

endpackage

// ----- rtl/smg_phase_div.sv -----
// smg_phase_div: pipelined restoring divider that turns an index into a phase
// depends on smg_pkg for stage and step counts
module smg_phase_div (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [smg_pkg::DIV_NUM_W-1:0]   num_i,
  input  logic [7:0]                      den_i,
  output logic [31:0]                     quo_o
);

  localparam int unsigned NS  = smg_pkg::DIV_STAGES;
  localparam int unsigned NST = smg_pkg::DIV_STEPS;
  localparam int unsigned NW  = smg_pkg::DIV_NUM_W;

  logic [NW-1:0] num_q [NS];
  logic [7:0]    rem_q [NS];
  logic [31:0]   quo_q [NS];
  logic [NW-1:0] num_in [NS];
  logic [7:0]    rem_in [NS];
  logic [31:0]   quo_in [NS];
  logic [NW-1:0] num_d [NS];
  logic [7:0]    rem_d [NS];
  logic [31:0]   quo_d [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    // stage inputs
    if (s == 0) begin : g_first
      assign num_in[s] = num_i;
      assign rem_in[s] = 8'd0;
      assign quo_in[s] = 32'd0;
    end else begin : g_next
      assign num_in[s] = num_q[s-1];
      assign rem_in[s] = rem_q[s-1];
      assign quo_in[s] = quo_q[s-1];
    end

    // NST quotient bits per stage
    always_comb begin : c_steps
      logic [NW-1:0] n;
      logic [7:0]    r;
      logic [31:0]   q;
      logic [8:0]    t;
      n = num_in[s];
      r = rem_in[s];
      q = quo_in[s];
      for (int b = 0; b < NST; b++) begin
        t = {r, n[NW-1]};
        n = n << 1;
        if (t >= {1'b0, den_i}) begin
          r = 8'(t - {1'b0, den_i});
          q = {q[30:0], 1'b1};
        end else begin
          r = t[7:0];
          q = {q[30:0], 1'b0};
        end
      end
      num_d[s] = n;
      rem_d[s] = r;
      quo_d[s] = q;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s] <= num_d[s];
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
      end
    end
  end

  assign quo_o = quo_q[NS-1];

endmodule

// ----- rtl/smg_sincos.sv -----
// smg_sincos: pipelined fixed point sine and cosine of a 32 bit phase (Q30 out)
// depends on smg_pkg for series constants; pipeline depth of smg_pkg::SC_LAT register stages
module smg_sincos (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        phase_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  localparam int unsigned NS = smg_pkg::SIN_STEPS;
  localparam int unsigned NC = smg_pkg::COS_STEPS;
  localparam logic [30:0] ONE = 31'h4000_0000;

  logic [29:0] r_raw;
  logic [29:0] r_red;
  logic        swap;
  logic [63:0] pip_q;
  logic [1:0]  quad_q [1:15];
  logic        swap_q [1:15];
  logic [29:0] x_q [2:13];
  logic [29:0] x2_q [3:13];
  logic [59:0] sp_q [NS];
  logic [61:0] sq_q [NS];
  logic [30:0] st_in [NS];
  logic [59:0] cp_q [NC];
  logic [61:0] cq_q [NC];
  logic [30:0] ct_in [NC];
  logic [30:0] st_fin;
  logic [30:0] c0;
  logic [29:0] s0_q [14:15];
  logic [30:0] a_w;
  logic [30:0] b_w;
  logic signed [31:0] av;
  logic signed [31:0] bv;

  // fold the phase into the first eighth of a turn
  assign r_raw = phase_i[29:0];
  assign swap  = r_raw > 30'h2000_0000;
  assign r_red = swap ? 30'(ONE - {1'b0, r_raw}) : r_raw;

  // angle, its square and the delay lines
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pip_q     <= {34'd0, r_red} * {30'd0, smg_pkg::PI_Q32};
      quad_q[1] <= phase_i[31:30];
      swap_q[1] <= swap;
      for (int s = 2; s <= 15; s++) begin
        quad_q[s] <= quad_q[s-1];
        swap_q[s] <= swap_q[s-1];
      end
      x_q[2] <= 30'((pip_q + 64'h1_0000_0000) >> 33);
      for (int s = 3; s <= 13; s++) begin
        x_q[s] <= x_q[s-1];
      end
      x2_q[3] <= 30'(({30'd0, x_q[2]} * {30'd0, x_q[2]}) >> 30);
      for (int s = 4; s <= 13; s++) begin
        x2_q[s] <= x2_q[s-1];
      end
      s0_q[14] <= 30'(({30'd0, x_q[13]} * {29'd0, st_fin}) >> 30);
      s0_q[15] <= s0_q[14];
    end
  end

  // sine series, one horner step per two stages
  for (genvar k = 0; k < NS; k++) begin : g_sin
    localparam logic [31:0] MUL = smg_pkg::sin_mul(k);
    if (k == 0) begin : g_first
      assign st_in[k] = ONE;
    end else begin : g_next
      assign st_in[k] = ONE - 31'(sq_q[k-1] >> smg_pkg::sin_shift(k - 1));
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sp_q[k] <= {30'd0, x2_q[3+2*k]} * {29'd0, st_in[k]};
        sq_q[k] <= {32'd0, sp_q[k][59:30]} * {30'd0, MUL};
      end
    end
  end

  // cosine series
  for (genvar k = 0; k < NC; k++) begin : g_cos
    localparam logic [31:0] MUL = smg_pkg::cos_mul(k);
    if (k == 0) begin : g_first
      assign ct_in[k] = ONE;
    end else begin : g_next
      assign ct_in[k] = ONE - 31'(cq_q[k-1] >> smg_pkg::cos_shift(k - 1));
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cp_q[k] <= {30'd0, x2_q[3+2*k]} * {29'd0, ct_in[k]};
        cq_q[k] <= {32'd0, cp_q[k][59:30]} * {30'd0, MUL};
      end
    end
  end

  assign st_fin = ONE - 31'(sq_q[NS-1] >> smg_pkg::sin_shift(NS - 1));
  assign c0     = ONE - 31'(cq_q[NC-1] >> smg_pkg::cos_shift(NC - 1));

  // undo the fold and apply the quadrant
  assign a_w = swap_q[15] ? c0 : {1'b0, s0_q[15]};
  assign b_w = swap_q[15] ? {1'b0, s0_q[15]} : c0;
  assign av  = {1'b0, a_w};
  assign bv  = {1'b0, b_w};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (quad_q[15])
        2'd0: begin
          sin_o <= av;
          cos_o <= bv;
        end
        2'd1: begin
          sin_o <= bv;
          cos_o <= -av;
        end
        2'd2: begin
          sin_o <= -av;
          cos_o <= -bv;
        end
        default: begin
          sin_o <= -bv;
          cos_o <= av;
        end
      endcase
    end
  end

endmodule

// ----- rtl/uv_sphere_mesh_generator.sv -----
// uv_sphere_mesh_generator: top level, vertex and triangle generator for a uv sphere
// depends on smg_pkg, smg_phase_div and smg_sincos
// an input goes through the datapath and the tail stage to the output register
// throughput: one input per cycle while in_ready_o is high; the single output port sets the rate
// and the 27 stage datapath (divider, sine/cosine) stalls while a two triangle cell holds it
// reset: configuration returns to its defaults and the pipeline empties; no clearing pass
module uv_sphere_mesh_generator #(
  parameter int unsigned COUNT_BITS = 8,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  smg_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output smg_pkg::out_t   out_data_o,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [31:0]     cfg_data_i
);

  localparam logic [7:0] CMASK = (COUNT_BITS >= 8) ? 8'hFF : 8'((1 << COUNT_BITS) - 1);
  localparam int unsigned CSH     = 31 - FRAC_BITS;
  localparam int unsigned DIV_END = smg_pkg::DIV_STAGES;
  localparam int unsigned SC_END  = DIV_END + smg_pkg::SC_LAT;
  localparam int unsigned LAST    = SC_END + 5;
  localparam int unsigned NW      = smg_pkg::DIV_NUM_W;

  // configuration registers
  logic [7:0]         stack_q;
  logic [7:0]         sector_q;
  logic signed [31:0] cx_q;
  logic signed [31:0] cy_q;
  logic signed [31:0] cz_q;
  logic [30:0]        radius_q;

  // sideband that travels with each transaction
  logic            sb_vld_q [0:LAST];
  smg_pkg::op_e    sb_op_q  [0:LAST];
  logic            sb_err_q [0:LAST];
  logic [7:0]      sb_i_q   [0:LAST];
  logic [7:0]      sb_j_q   [0:LAST];

  logic            adv;
  logic            o_load;
  logic            t_take;
  logic [7:0]      in_i;
  logic [7:0]      in_j;
  logic            in_err;

  logic [NW-1:0]      sec_num;
  logic [NW-1:0]      stk_num;
  logic [31:0]        sec_ph;
  logic [31:0]        stk_quo;
  logic [31:0]        stk_ph;
  logic signed [31:0] ss_w;
  logic signed [31:0] cs_w;
  logic signed [31:0] st_w;
  logic signed [31:0] ct_w;

  logic signed [63:0] nxp_q;
  logic signed [63:0] nzp_q;
  logic signed [31:0] ny1_q;
  logic signed [31:0] nx_q;
  logic signed [31:0] ny_q;
  logic signed [31:0] nz_q;
  logic signed [63:0] pxp_q;
  logic signed [63:0] pyp_q;
  logic signed [63:0] pzp_q;
  logic signed [33:0] rpx_q;
  logic signed [33:0] rpy_q;
  logic signed [33:0] rpz_q;
  logic signed [31:0] posx_q;
  logic signed [31:0] posy_q;
  logic signed [31:0] posz_q;
  logic [16:0]        colr_q [3];
  logic [16:0]        colg_q [3];
  logic [16:0]        colb_q [3];

  smg_pkg::out_t r0_w;
  smg_pkg::out_t r1_w;
  logic          two_w;
  smg_pkg::out_t t_r0_q;
  smg_pkg::out_t t_r1_q;
  logic          t_two_q;
  logic          t_vld_q;
  logic          sub_q;
  logic          o_vld_q;
  smg_pkg::out_t o_data_q;

  // signed shift by 30 with rounding half away from zero
  function automatic logic signed [63:0] rnd30(logic signed [63:0] v);
    logic signed [63:0] adj;
    adj = (v < 0) ? 64'sd1 : 64'sd0;
    return (v + 64'sh2000_0000 - adj) >>> 30;
  endfunction

  // clamp to the signed 32 bit range
  function automatic logic signed [31:0] sat32(logic signed [34:0] v);
    if (v > 35'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -35'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return 32'(v);
  endfunction

  // 0.5 + 0.5 * normal, rounded to the color format
  function automatic logic [16:0] color(logic signed [31:0] n);
    logic signed [32:0] v;
    v = 33'sh0_4000_0000 + 33'(n);
    return 17'((33'(v) + (33'd1 << (CSH - 1))) >> CSH);
  endfunction

  // one triangle result
  function automatic smg_pkg::out_t make_tri(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                             logic lst);
    smg_pkg::out_t r;
    r          = '0;
    r.kind     = smg_pkg::KIND_TRIANGLE;
    r.corner_a = a;
    r.corner_b = b;
    r.corner_c = c;
    r.last     = lst;
    return r;
  endfunction

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_q  <= 8'd16;
      sector_q <= 8'd32;
      cx_q     <= '0;
      cy_q     <= '0;
      cz_q     <= '0;
      radius_q <= 31'd65536;
    end else if (cfg_we_i) begin
      case (smg_pkg::cfg_e'(cfg_idx_i))
        smg_pkg::CFG_STACK_COUNT:  stack_q  <= cfg_data_i[7:0] & CMASK;
        smg_pkg::CFG_SECTOR_COUNT: sector_q <= cfg_data_i[7:0] & CMASK;
        smg_pkg::CFG_CENTER_X:     cx_q     <= cfg_data_i;
        smg_pkg::CFG_CENTER_Y:     cy_q     <= cfg_data_i;
        smg_pkg::CFG_CENTER_Z:     cz_q     <= cfg_data_i;
        smg_pkg::CFG_RADIUS:       radius_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // output handshake and global advance
  assign o_load     = !o_vld_q || out_ready_i;
  assign t_take     = t_vld_q && o_load && (sub_q || !t_two_q);
  assign adv        = !t_vld_q || t_take;
  assign in_ready_o = adv;

  // range check at entry
  assign in_i   = in_data_i.ring_index & CMASK;
  assign in_j   = in_data_i.segment_index & CMASK;
  assign in_err = (stack_q == 8'd0) || (sector_q == 8'd0) ||
                  ((in_data_i.opcode == smg_pkg::OP_VERTEX) &&
                   ((in_i > stack_q) || (in_j > sector_q))) ||
                  ((in_data_i.opcode == smg_pkg::OP_CELL) &&
                   ((in_i >= stack_q) || (in_j >= sector_q)));

  // valid bits of the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= LAST; s++) begin
        sb_vld_q[s] <= 1'b0;
      end
      t_vld_q <= 1'b0;
    end else if (adv) begin
      sb_vld_q[0] <= in_valid_i;
      for (int s = 1; s <= LAST; s++) begin
        sb_vld_q[s] <= sb_vld_q[s-1];
      end
      t_vld_q <= sb_vld_q[LAST];
    end
  end

  // sideband payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_op_q[0]  <= in_data_i.opcode;
      sb_err_q[0] <= in_err;
      sb_i_q[0]   <= in_i;
      sb_j_q[0]   <= in_j;
      for (int s = 1; s <= LAST; s++) begin
        sb_op_q[s]  <= sb_op_q[s-1];
        sb_err_q[s] <= sb_err_q[s-1];
        sb_i_q[s]   <= sb_i_q[s-1];
        sb_j_q[s]   <= sb_j_q[s-1];
      end
    end
  end

  // phases: round(j * 2^32 / sectors) and round(i * 2^31 / stacks)
  assign sec_num = {sb_j_q[0], 25'd0, sector_q[7:1]};
  assign stk_num = {1'b0, sb_i_q[0], 24'd0, stack_q[7:1]};

  smg_phase_div u_sec_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (sec_num),
    .den_i (sector_q),
    .quo_o (sec_ph)
  );

  smg_phase_div u_stk_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (stk_num),
    .den_i (stack_q),
    .quo_o (stk_quo)
  );

  assign stk_ph = 32'h4000_0000 - stk_quo;

  smg_sincos u_sec_sc (
    .clk_i   (clk_i),
    .en_i    (adv),
    .phase_i (sec_ph),
    .sin_o   (ss_w),
    .cos_o   (cs_w)
  );

  smg_sincos u_stk_sc (
    .clk_i   (clk_i),
    .en_i    (adv),
    .phase_i (stk_ph),
    .sin_o   (st_w),
    .cos_o   (ct_w)
  );

  // normal, position and color stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      nxp_q  <= 64'(ct_w) * 64'(ss_w);
      nzp_q  <= 64'(ct_w) * 64'(cs_w);
      ny1_q  <= st_w;
      nx_q   <= 32'(rnd30(nxp_q));
      ny_q   <= ny1_q;
      nz_q   <= 32'(rnd30(nzp_q));
      pxp_q  <= 64'(signed'({1'b0, radius_q})) * 64'(nx_q);
      pyp_q  <= 64'(signed'({1'b0, radius_q})) * 64'(ny_q);
      pzp_q  <= 64'(signed'({1'b0, radius_q})) * 64'(nz_q);
      colr_q[0] <= color(nx_q);
      colg_q[0] <= color(ny_q);
      colb_q[0] <= color(nz_q);
      rpx_q  <= 34'(rnd30(pxp_q));
      rpy_q  <= 34'(rnd30(pyp_q));
      rpz_q  <= 34'(rnd30(pzp_q));
      posx_q <= sat32(35'(cx_q) + 35'(rpx_q));
      posy_q <= sat32(35'(cy_q) + 35'(rpy_q));
      posz_q <= sat32(35'(cz_q) + 35'(rpz_q));
      for (int s = 1; s < 3; s++) begin
        colr_q[s] <= colr_q[s-1];
        colg_q[s] <= colg_q[s-1];
        colb_q[s] <= colb_q[s-1];
      end
    end
  end

  // result assembly at the end of the pipeline
  always_comb begin
    logic [15:0] s1;
    logic [15:0] k1;
    logic [15:0] k2;
    logic [15:0] jj;
    logic        top;
    logic        bot;
    s1     = 16'(sector_q) + 16'd1;
    k1     = 16'(16'(sb_i_q[LAST]) * s1);
    k2     = k1 + s1;
    jj     = 16'(sb_j_q[LAST]);
    top    = sb_i_q[LAST] == 8'd0;
    bot    = ({1'b0, sb_i_q[LAST]} + 9'd1) == {1'b0, stack_q};
    r0_w   = '0;
    r1_w   = '0;
    two_w  = 1'b0;
    r0_w.last = 1'b1;
    if (sb_err_q[LAST]) begin
      r0_w.kind = smg_pkg::KIND_RANGE;
    end else if (sb_op_q[LAST] == smg_pkg::OP_VERTEX) begin
      r0_w.kind        = smg_pkg::KIND_VERTEX;
      r0_w.pos_x       = posx_q;
      r0_w.pos_y       = posy_q;
      r0_w.pos_z       = posz_q;
      r0_w.color_red   = colr_q[2];
      r0_w.color_green = colg_q[2];
      r0_w.color_blue  = colb_q[2];
    end else if (top && bot) begin
      // single ring: top then bottom triangle
      two_w = 1'b1;
      r0_w  = make_tri(jj, s1 + jj, s1 + jj + 16'd1, 1'b0);
      r1_w  = make_tri(k1 + jj, k2 + jj, k1 + jj + 16'd1, 1'b1);
    end else if (top) begin
      r0_w = make_tri(jj, s1 + jj, s1 + jj + 16'd1, 1'b1);
    end else if (bot) begin
      r0_w = make_tri(k1 + jj, k2 + jj, k1 + jj + 16'd1, 1'b1);
    end else begin
      two_w = 1'b1;
      r0_w  = make_tri(k1 + jj, k2 + jj, k2 + jj + 16'd1, 1'b0);
      r1_w  = make_tri(k1 + jj, k2 + jj + 16'd1, k1 + jj + 16'd1, 1'b1);
    end
  end

  // tail stage payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_r0_q  <= r0_w;
      t_r1_q  <= r1_w;
      t_two_q <= two_w;
    end
  end

  // output register, second triangle follows the first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
      sub_q   <= 1'b0;
    end else if (o_load) begin
      o_vld_q <= t_vld_q;
      sub_q   <= t_vld_q && t_two_q && !sub_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_load && t_vld_q) begin
      o_data_q <= sub_q ? t_r1_q : t_r0_q;
    end
  end

  assign out_valid_o = o_vld_q;
  assign out_data_o  = o_data_q;

endmodule
